/* sv/kssm_pkg.sv */
// shared constants, types and helpers for the kth smallest matrix selector
package kssm_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int VAL_W      = 32;
  localparam int RANK_W     = 13;
  localparam int CNT_W      = 7;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int ELEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ELEM_AW    = ROW_W + COL_W;
  localparam int HEAP_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int HEAP_AW    = 6;
  localparam int KEY_W      = VAL_W + ROW_W + COL_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  // order key: value with flipped sign bit, then row, then column
  function automatic key_t make_key(logic [VAL_W-1:0] v, logic [ROW_W-1:0] r,
                                    logic [COL_W-1:0] c);
    return {~v[VAL_W-1], v[VAL_W-2:0], r, c};
  endfunction

  function automatic logic [VAL_W-1:0] key_value(key_t k);
    return {~k[KEY_W-1], k[KEY_W-2:ROW_W+COL_W]};
  endfunction

  function automatic logic [CNT_W-1:0] clamp_count(logic [CFG_W-1:0] v,
                                                   logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

/* sv/kssm_in_if.sv */
// input channel: load or query items
interface kssm_in_if;
  import kssm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [ROW_W-1:0]        row_index;
  logic [COL_W-1:0]        col_index;
  logic signed [VAL_W-1:0] element_value;
  logic [RANK_W-1:0]       pick_rank;

  modport source (output valid, mode, row_index, col_index, element_value, pick_rank,
                  input ready);
  modport sink (input valid, mode, row_index, col_index, element_value, pick_rank,
                output ready);
endinterface

/* sv/kssm_out_if.sv */
// output channel: selected element per query
interface kssm_out_if;
  import kssm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] selected_value;
  logic                    rank_exceeded;

  modport source (output valid, selected_value, rank_exceeded, input ready);
  modport sink (input valid, selected_value, rank_exceeded, output ready);
endinterface

/* sv/kssm_ram.sv */
// generic single write, single read ram with registered read data
module kssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

/* sv/kth_smallest_sorted_matrix.sv */
// top level: kth smallest element of a sorted matrix by heap merge
//
// in_ch carries load items (mode 0) that write one element into the
// 64x64 element ram, and query items (mode 1) that ask for the rank k
// element. out_ch returns one transfer per query: the value and a flag
// set when k is zero or above row_count*col_count. Loads give nothing.
// row_count and col_count are written on the cfg port; the user must
// do so only while idle, as the block does not enforce it. A query
// runs a sequencer around the heap ram (one read and one write port,
// registered read data): it seeds n heads, then per pop does a
// sift-down plus a push, with n = min(k, rows or cols); up to k pops
// in total.
// in_ch is ready only while no query runs. A finished result sits in an
// output register; if the receiver stalls, loads are still taken and the
// next query runs, but its result waits in S_OUT for the register to drain.
// Reset clears the control state and restores both counts to 1; the
// rams are not cleared.
module kth_smallest_sorted_matrix
  import kssm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  kssm_in_if.sink              in_ch,
  kssm_out_if.source           out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SEED, S_PFETCH, S_PUP, S_PCMP, S_LOOP, S_TOP,
    S_LAST, S_DL, S_DR, S_DCMP, S_NEXT, S_BR, S_OUT
  } state_e;

  state_e state_q;

  logic [CFG_W-1:0]  row_cfg_q, col_cfg_q;
  logic [CNT_W-1:0]  rows_q, cols_q, n_q, cnt_q, size_q;
  logic [RANK_W-1:0] k_q, pops_q, total_q;
  logic              horiz_q, seeding_q, right_q;
  logic [ROW_W-1:0]  pr_q;
  logic [COL_W-1:0]  pc_q;
  logic [HEAP_AW-1:0] i_q;
  key_t              x_q, top_q, cl_q;
  logic [VAL_W-1:0]  res_val_q, out_val_q;
  logic              res_exc_q, out_val_valid_q, out_exc_q;

  logic               in_acc;
  logic               e_we;
  logic [ELEM_AW-1:0] e_raddr;
  logic [VAL_W-1:0]   e_rdata;
  logic               h_we;
  logic [HEAP_AW-1:0] h_waddr, h_raddr;
  key_t               h_wdata, h_rdata;

  logic [ROW_W-1:0]   push_r;
  logic [COL_W-1:0]   push_c;
  logic               push_ok;
  logic [CNT_W:0]     lch, rch;
  logic [HEAP_AW-1:0] parent;
  logic               x_lt_rd, cl_lt_x, rd_lt_best, pick_right, pick_left;
  key_t               best;
  logic [CNT_W-1:0]   top_row_n, top_col_n;

  assign in_ch.ready       = (state_q == S_IDLE);
  assign in_acc            = in_ch.valid & in_ch.ready;
  assign e_we              = in_acc & (in_ch.mode == MODE_LOAD);
  assign out_ch.valid          = out_val_valid_q;
  assign out_ch.selected_value = out_val_q;
  assign out_ch.rank_exceeded  = out_exc_q;

  assign lch    = {i_q, 1'b1};
  assign rch    = lch + (CNT_W+1)'(1);
  assign parent = HEAP_AW'((i_q - HEAP_AW'(1)) >> 1);
  assign x_lt_rd    = x_q < h_rdata;
  assign cl_lt_x    = cl_q < x_q;
  assign best       = cl_lt_x ? cl_q : x_q;
  assign rd_lt_best = h_rdata < best;
  assign pick_right = right_q & rd_lt_best;
  assign pick_left  = cl_lt_x & ~pick_right;
  assign top_row_n  = {1'b0, top_q[ROW_W+COL_W-1:COL_W]} + CNT_W'(1);
  assign top_col_n  = {1'b0, top_q[COL_W-1:0]} + CNT_W'(1);

  always_comb begin
    push_r  = '0;
    push_c  = '0;
    push_ok = 1'b0;
    if (state_q == S_SEED) begin
      push_ok = (cnt_q != n_q);
      if (horiz_q) push_r = cnt_q[ROW_W-1:0];
      else push_c = cnt_q[COL_W-1:0];
    end else if (horiz_q) begin
      push_r  = top_q[ROW_W+COL_W-1:COL_W];
      push_c  = top_col_n[COL_W-1:0];
      push_ok = top_col_n < cols_q;
    end else begin
      push_r  = top_row_n[ROW_W-1:0];
      push_c  = top_q[COL_W-1:0];
      push_ok = top_row_n < rows_q;
    end
  end

  always_comb begin
    h_we    = 1'b0;
    h_waddr = i_q;
    h_wdata = x_q;
    h_raddr = '0;
    e_raddr = {push_r, push_c};
    unique case (state_q)
      S_PUP: begin
        if (i_q == '0) h_we = 1'b1;
        else h_raddr = parent;
      end
      S_PCMP: begin
        h_we = 1'b1;
        if (x_lt_rd) h_wdata = h_rdata;
      end
      S_LOOP: begin
        if (size_q == '0 || pops_q == '0) begin
          e_raddr = {ROW_W'(rows_q - CNT_W'(1)), COL_W'(cols_q - CNT_W'(1))};
        end
      end
      S_TOP:  h_raddr = HEAP_AW'(size_q - CNT_W'(1));
      S_DL: begin
        if (lch < {1'b0, size_q}) h_raddr = lch[HEAP_AW-1:0];
        else h_we = 1'b1;
      end
      S_DR:   h_raddr = rch[HEAP_AW-1:0];
      S_DCMP: begin
        h_we = 1'b1;
        if (pick_right) h_wdata = h_rdata;
        else if (pick_left) h_wdata = cl_q;
      end
      default: ;
    endcase
  end

  kssm_ram #(.WIDTH(VAL_W), .DEPTH(ELEM_DEPTH)) u_elem (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i ({in_ch.row_index, in_ch.col_index}),
    .wdata_i (in_ch.element_value),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  kssm_ram #(.WIDTH(KEY_W), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      row_cfg_q       <= CFG_W'(1);
      col_cfg_q       <= CFG_W'(1);
      size_q          <= '0;
      pops_q          <= '0;
      out_val_valid_q <= 1'b0;
      seeding_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ROW_COUNT) row_cfg_q <= cfg_data_i;
        else col_cfg_q <= cfg_data_i;
      end
      if (out_ch.ready && state_q != S_OUT) out_val_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_ch.mode == MODE_QUERY) begin
            rows_q  <= clamp_count(row_cfg_q, CNT_W'(MAX_ROWS));
            cols_q  <= clamp_count(col_cfg_q, CNT_W'(MAX_COLS));
            k_q     <= in_ch.pick_rank;
            state_q <= S_START;
          end
        end
        S_START: begin
          total_q   <= RANK_W'(rows_q) * RANK_W'(cols_q);
          horiz_q   <= rows_q < cols_q;
          if ({6'd0, (rows_q < cols_q) ? rows_q : cols_q} > k_q) n_q <= k_q[CNT_W-1:0];
          else n_q <= (rows_q < cols_q) ? rows_q : cols_q;
          pops_q    <= k_q;
          size_q    <= '0;
          cnt_q     <= '0;
          seeding_q <= 1'b1;
          state_q   <= S_SEED;
        end
        S_SEED: begin
          if (push_ok) begin
            pr_q    <= push_r;
            pc_q    <= push_c;
            cnt_q   <= cnt_q + CNT_W'(1);
            state_q <= S_PFETCH;
          end else begin
            seeding_q <= 1'b0;
            state_q   <= S_LOOP;
          end
        end
        S_PFETCH: begin
          x_q     <= make_key(e_rdata, pr_q, pc_q);
          i_q     <= size_q[HEAP_AW-1:0];
          size_q  <= size_q + CNT_W'(1);
          state_q <= S_PUP;
        end
        S_PUP: begin
          if (i_q == '0) state_q <= seeding_q ? S_SEED : S_LOOP;
          else state_q <= S_PCMP;
        end
        S_PCMP: begin
          if (x_lt_rd) begin
            i_q     <= parent;
            state_q <= S_PUP;
          end else begin
            state_q <= seeding_q ? S_SEED : S_LOOP;
          end
        end
        S_LOOP: begin
          if (size_q == '0 || pops_q == '0) state_q <= S_BR;
          else state_q <= S_TOP;
        end
        S_TOP: begin
          top_q  <= h_rdata;
          pops_q <= pops_q - RANK_W'(1);
          if (pops_q == RANK_W'(1)) begin
            res_val_q <= key_value(h_rdata);
            res_exc_q <= k_q > total_q;
            state_q   <= S_OUT;
          end else begin
            size_q <= size_q - CNT_W'(1);
            if (size_q == CNT_W'(1)) state_q <= S_NEXT;
            else state_q <= S_LAST;
          end
        end
        S_LAST: begin
          x_q     <= h_rdata;
          i_q     <= '0;
          state_q <= S_DL;
        end
        S_DL: begin
          if (lch < {1'b0, size_q}) state_q <= S_DR;
          else state_q <= S_NEXT;
        end
        S_DR: begin
          cl_q    <= h_rdata;
          right_q <= rch < {1'b0, size_q};
          state_q <= S_DCMP;
        end
        S_DCMP: begin
          if (pick_right) begin
            i_q     <= rch[HEAP_AW-1:0];
            state_q <= S_DL;
          end else if (pick_left) begin
            i_q     <= lch[HEAP_AW-1:0];
            state_q <= S_DL;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (push_ok) begin
            pr_q    <= push_r;
            pc_q    <= push_c;
            state_q <= S_PFETCH;
          end else begin
            state_q <= S_LOOP;
          end
        end
        S_BR: begin
          res_val_q <= e_rdata;
          res_exc_q <= (k_q == '0) || (k_q > total_q);
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (!out_val_valid_q || out_ch.ready) begin
            out_val_valid_q <= 1'b1;
            out_val_q       <= res_val_q;
            out_exc_q       <= res_exc_q;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
